[hdl/xsf_pkg.sv]
// Package for the XOR sprite framebuffer: geometry constants, codes, tables and shared types.
`timescale 1ns / 1ps
`default_nettype none

package xsf_pkg;

    localparam int SCREEN_WIDTH  = 64;
    localparam int SCREEN_HEIGHT = 32;
    localparam int ROW_BYTES     = SCREEN_WIDTH / 8;
    localparam int STORE_BYTES   = ROW_BYTES * SCREEN_HEIGHT;
    localparam int ADDR_W        = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;

    localparam int S_DATA_W = 40;
    localparam int M_DATA_W = 16;
    localparam int PADDR_W  = 3;

    typedef enum logic [1:0] {
        CMD_DRAW  = 2'd0,
        CMD_CLEAR = 2'd1,
        CMD_READ  = 2'd2,
        CMD_FETCH = 2'd3
    } cmd_t;

    // Register select is taken from paddr[2].
    localparam logic REG_WRAP_H = 1'b0;
    localparam logic REG_WRAP_V = 1'b1;

    typedef logic [255:0][7:0] mod_tab_t;

    // Builds a table of i modulo m for every 8-bit i, by counting.
    function automatic mod_tab_t build_mod(input int m);
        mod_tab_t tab;
        int       r;
        r = 0;
        for (int i = 0; i < 256; i++)
        begin
            tab[i] = 8'(r);
            r = r + 1;
            if (r == m)
            begin
                r = 0;
            end
        end
        return tab;
    endfunction

    localparam mod_tab_t X_MOD = build_mod(SCREEN_WIDTH);
    localparam mod_tab_t Y_MOD = build_mod(SCREEN_HEIGHT);

    typedef struct packed {
        logic              on_screen;
        logic              second;
        logic [ADDR_W-1:0] addr0;
        logic [ADDR_W-1:0] addr1;
        logic [7:0]        bits0;
        logic [7:0]        bits1;
    } geom_t;

endpackage

`default_nettype wire

[hdl/xsf_geom.sv]
// Placement logic for one sprite row: wrap, reject, drop, byte addresses and shifted bits.
`timescale 1ns / 1ps
`default_nettype none

module xsf_geom
    import xsf_pkg::*;
(
    input  wire logic [7:0] pos_x,
    input  wire logic [7:0] pos_y,
    input  wire logic [3:0] row_index,
    input  wire logic [7:0] sprite_bits,
    input  wire logic       wrap_horizontal,
    input  wire logic       wrap_vertical,
    output geom_t           geom
);

    logic        reject;
    logic [7:0]  x_w;
    logic [7:0]  y_w;
    logic [8:0]  line;
    logic [2:0]  sh;
    logic        last_col;
    logic [15:0] pos_full;
    logic [15:0] pos_next;
    logic [15:0] shifted;

    always_comb
    begin
        reject = (!wrap_horizontal && (9'(pos_x) >= 9'(SCREEN_WIDTH))) ||
                 (!wrap_vertical && (9'(pos_y) >= 9'(SCREEN_HEIGHT)));
        x_w = wrap_horizontal ? X_MOD[pos_x] : pos_x;
        y_w = wrap_vertical ? Y_MOD[pos_y] : pos_y;
        line = 9'(y_w) + 9'(row_index);
        sh = x_w[2:0];
        last_col = 9'(x_w) >= 9'(SCREEN_WIDTH - 8);
        pos_full = 16'(ROW_BYTES) * 16'(line) + 16'(x_w[7:3]);
        // On the last byte column the right byte wraps to the start of the same row.
        pos_next = last_col ? (pos_full + 16'd1 - 16'(ROW_BYTES)) : (pos_full + 16'd1);
        shifted = {sprite_bits, 8'h00} >> sh;

        geom.on_screen = !reject && (line < 9'(SCREEN_HEIGHT));
        geom.second = geom.on_screen && (sh != 3'd0) && (!last_col || wrap_horizontal);
        geom.addr0 = pos_full[ADDR_W-1:0];
        geom.addr1 = pos_next[ADDR_W-1:0];
        geom.bits0 = shifted[15:8];
        geom.bits1 = shifted[7:0];
    end

endmodule

`default_nettype wire

[hdl/xor_sprite_framebuffer.sv]
// Top level of the XOR sprite framebuffer: command sequencer, frame memory and output register.
`timescale 1ns / 1ps
`default_nettype none

// A 1-bit-per-pixel framebuffer driven by one command per input transaction.
// Input: s_tuser carries the command, s_tdata the draw and read fields.
// Output: one result transaction per command on m_tdata (hit, read_byte, dirty).
// Configuration: two APB registers, wrap_horizontal at 0x0 and wrap_vertical at 0x4.
// One command is in work at a time; s_tready is high while the sequencer is idle.
// Each accepted command steps from idle through the states it needs: a draw row that
// touches two bytes passes S_B0 and S_B1, a one-byte draw row or a read passes S_B0,
// and clear, fetch and a draw row that is rejected or below the screen go to S_OUT. The
// steps come from the read-modify-write of each byte through the frame memory, which has
// one read and one write port and whose read data arrives in the cycle after the address.
// The result is loaded into the output register from S_OUT once that register is free.
// Clear takes effect at once through a valid bit per byte, so it needs no sweep.
// Reset clears all bytes, sets the changed flag, clears the hit flag and sets both
// wrap registers. A result waits in the output register while m_tready is low;
// the next command may be accepted meanwhile but finishes only once the register frees.
module xor_sprite_framebuffer
    import xsf_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    // s_tdata: pos_x, pos_y, row_index, sprite_bits, byte_address, zero padding
    input  wire logic [S_DATA_W-1:0] s_tdata,
    // s_tuser: command
    input  wire logic [1:0]          s_tuser,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    // m_tdata: hit, read_byte, dirty, zero padding
    output logic [M_DATA_W-1:0]      m_tdata,
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [PADDR_W-1:0]  paddr,
    input  wire logic [31:0]         pwdata,
    output logic [31:0]              prdata,
    output logic                     pready
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_B0   = 4'b0010,
        S_B1   = 4'b0100,
        S_OUT  = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    logic wrap_h_reg, wrap_v_reg;
    logic hit_reg, dirty_reg;

    cmd_t       cmd_in;
    logic [7:0] pos_x, pos_y, sprite_bits, byte_address;
    logic [3:0] row_index;
    logic       accept;
    geom_t      geom;

    cmd_t  cmd_reg;
    geom_t geom_reg;
    logic  in_range_reg;
    logic  res_dirty_reg;
    logic [7:0] res_byte_reg;
    logic  fwd_reg;
    logic [7:0] fwd_data_reg;

    logic [7:0] mem [STORE_BYTES];
    logic [STORE_BYTES-1:0] valid_reg;
    logic [7:0]        mem_q;
    logic [ADDR_W-1:0] raddr, raddr_q;
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [7:0]        wdata;
    logic [7:0]        rdata;
    logic [7:0]        b1_old;

    logic out_valid_reg;
    logic [M_DATA_W-1:0] out_data_reg;
    logic out_load;

    assign cmd_in       = cmd_t'(s_tuser);
    assign pos_x        = s_tdata[7:0];
    assign pos_y        = s_tdata[15:8];
    assign row_index    = s_tdata[19:16];
    assign sprite_bits  = s_tdata[27:20];
    assign byte_address = s_tdata[35:28];

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;

    xsf_geom u_geom (
        .pos_x           (pos_x),
        .pos_y           (pos_y),
        .row_index       (row_index),
        .sprite_bits     (sprite_bits),
        .wrap_horizontal (wrap_h_reg),
        .wrap_vertical   (wrap_v_reg),
        .geom            (geom)
    );

    // APB registers.
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_WRAP_V) ? {31'd0, wrap_v_reg} : {31'd0, wrap_h_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wrap_h_reg <= 1'b1;
            wrap_v_reg <= 1'b1;
        end
        else if (psel && penable && pwrite && pready)
        begin
            if (paddr[2] == REG_WRAP_H)
            begin
                wrap_h_reg <= pwdata[0];
            end
            else
            begin
                wrap_v_reg <= pwdata[0];
            end
        end
    end

    // Memory read and write ports.
    assign rdata  = valid_reg[raddr_q] ? mem_q : 8'h00;
    assign b1_old = fwd_reg ? fwd_data_reg : rdata;

    always_comb
    begin
        raddr = geom.addr0;
        we    = 1'b0;
        waddr = geom_reg.addr0;
        wdata = rdata ^ geom_reg.bits0;
        case (state_reg)
            S_IDLE:
            begin
                raddr = (cmd_in == CMD_READ) ? ADDR_W'(byte_address) : geom.addr0;
            end
            S_B0:
            begin
                raddr = geom_reg.addr1;
                we    = (cmd_reg == CMD_DRAW);
            end
            S_B1:
            begin
                raddr = geom_reg.addr1;
                we    = 1'b1;
                waddr = geom_reg.addr1;
                wdata = b1_old ^ geom_reg.bits1;
            end
            default:
            begin
                raddr = geom_reg.addr1;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        mem_q   <= mem[raddr];
        raddr_q <= raddr;
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (accept && (cmd_in == CMD_CLEAR))
        begin
            valid_reg <= '0;
        end
        else if (we)
        begin
            valid_reg[waddr] <= 1'b1;
        end
    end

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (cmd_in == CMD_READ || (cmd_in == CMD_DRAW && geom.on_screen))
                    begin
                        state_next = S_B0;
                    end
                    else
                    begin
                        state_next = S_OUT;
                    end
                end
            end
            S_B0:
            begin
                state_next = (cmd_reg == CMD_DRAW && geom_reg.second) ? S_B1 : S_OUT;
            end
            S_B1:
            begin
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            hit_reg   <= 1'b0;
            dirty_reg <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
            begin
                case (cmd_in)
                    CMD_DRAW:
                    begin
                        if (row_index == 4'd0)
                        begin
                            hit_reg <= 1'b0;
                        end
                        // A draw row that is not rejected marks the screen changed,
                        // even when it falls below the bottom edge.
                        if (!(!wrap_h_reg && (9'(pos_x) >= 9'(SCREEN_WIDTH))) &&
                            !(!wrap_v_reg && (9'(pos_y) >= 9'(SCREEN_HEIGHT))))
                        begin
                            dirty_reg <= 1'b1;
                        end
                    end
                    CMD_CLEAR:
                    begin
                        dirty_reg <= 1'b1;
                    end
                    CMD_FETCH:
                    begin
                        dirty_reg <= 1'b0;
                    end
                    default:
                    begin
                    end
                endcase
            end
            if (state_reg == S_B0 && cmd_reg == CMD_DRAW &&
                ((rdata & geom_reg.bits0) != 8'h00))
            begin
                hit_reg <= 1'b1;
            end
            if (state_reg == S_B1 && ((b1_old & geom_reg.bits1) != 8'h00))
            begin
                hit_reg <= 1'b1;
            end
        end
    end

    // Command payload and result fields.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg       <= cmd_in;
            geom_reg      <= geom;
            in_range_reg  <= 32'(byte_address) < STORE_BYTES;
            res_dirty_reg <= (cmd_in == CMD_FETCH) ? dirty_reg : 1'b0;
            res_byte_reg  <= 8'h00;
        end
        if (state_reg == S_B0)
        begin
            if (cmd_reg == CMD_READ && in_range_reg)
            begin
                res_byte_reg <= rdata;
            end
            // When both bytes share one address the second read misses this write.
            fwd_reg      <= (geom_reg.addr1 == geom_reg.addr0);
            fwd_data_reg <= wdata;
        end
    end

    // Output register.
    assign out_load = (state_reg == S_OUT) && (!out_valid_reg || m_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_data_reg <= {6'd0, res_dirty_reg, res_byte_reg,
                             (cmd_reg == CMD_DRAW) ? hit_reg : 1'b0};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

`default_nettype wire

[hdl/xsf_checker.sv]
// Port-level checker for the XOR sprite framebuffer and its bind statement.
`timescale 1ns / 1ps
`default_nettype none

module xsf_checker
    import xsf_pkg::*;
(
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                s_tvalid,
    input wire logic                s_tready,
    input wire logic                m_tvalid,
    input wire logic                m_tready,
    input wire logic [M_DATA_W-1:0] m_tdata
);

    // A stalled result holds its value.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // Only one command is in work: after a transaction the input closes.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted twice in a row");

    // Each result reports at most one of hit, read data and changed flag.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> $countones({m_tdata[0], |m_tdata[8:1], m_tdata[9]}) <= 1)
        else $error("result fields of several commands set at once");

    // A clock edge under reset leaves no result shown.
    assert property (@(posedge clk)
        !rst_n |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind xor_sprite_framebuffer xsf_checker u_xsf_checker (.*);

`default_nettype wire
